@@ sv/rv32_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32_pkg: shared types and constants
// Opcodes, state encoding and controller/datapath command structs.
// ----------------------------------------------------------------------------
package rv32_pkg;

   localparam logic [31:0] HALT_WORD = 32'h0ff00513;

   localparam logic [6:0] OP_LUI    = 7'd55;
   localparam logic [6:0] OP_AUIPC  = 7'd23;
   localparam logic [6:0] OP_JAL    = 7'd111;
   localparam logic [6:0] OP_JALR   = 7'd103;
   localparam logic [6:0] OP_BRANCH = 7'd99;
   localparam logic [6:0] OP_LOAD   = 7'd3;
   localparam logic [6:0] OP_STORE  = 7'd35;
   localparam logic [6:0] OP_IMM    = 7'd19;
   localparam logic [6:0] OP_REG    = 7'd51;

   localparam logic [0:0] CMD_WRITE = 1'b0;
   localparam logic [0:0] CMD_EXEC  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_EXEC,
      ST_MEM,
      ST_WB,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;   // write zero at clear pointer, advance
      logic host_write;   // latch request and perform byte write
      logic fetch_start;  // reset byte counter, start fetch
      logic fetch_step;   // read one fetch byte
      logic decode;       // latch register operands
      logic exec;         // compute results
      logic mem_step;     // one load/store byte
      logic wb;           // commit rf and pc
      logic load_rsp;     // load output register
      logic no_op;        // step with nothing happening (halted)
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic fetch_done;
      logic fetch_fault;
      logic is_mem;
      logic mem_done;
      logic halted;
   } stat_type;

endpackage

@@ sv/rv32_stream_if.sv @@
// ----------------------------------------------------------------------------
// rv32_stream_if: valid/ready channel
// Carries one word with a generic payload.
// ----------------------------------------------------------------------------
interface rv32_stream_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/rv32i_instruction_executor_core.sv @@
// ----------------------------------------------------------------------------
// rv32i_instruction_executor_core: RV32I core with private byte memory
// Sequence, request taken to response loaded: a memory write or halted step goes
// straight to the response, as does a faulted fetch; a step does 4 fetch byte
// reads, decode, execute, writeback and response; a load or store adds a memory
// phase. Throughput is one word at a time; the next word can be taken the cycle
// after the response is loaded. After reset a clearing pass zeroes memory.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor_core #(
   parameter int MEM_ADDR_BITS = 19
) (
   input logic    clock,
   input logic    reset,
   rv32_stream_if.sink   req,
   rv32_stream_if.source rsp
);
   rv32_pkg::ctrl_type ctrl;
   rv32_pkg::stat_type stat;
   logic [31:0] o_pc, o_val;
   logic        o_wr, o_halt, o_fault;
   logic [4:0]  o_rd;
   logic [7:0]  o_exit;

   // req payload: {command, address, data_byte}
   // rsp payload: {next_pc, reg_written, dest_reg, write_value, halted, exit_code, fault}
   rv32_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.payload[27]),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .ctrl(ctrl)
   );

   rv32_datapath #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_address(req.payload[26:8]), .req_data_byte(req.payload[7:0]),
      .rsp_next_pc(o_pc), .rsp_reg_written(o_wr), .rsp_dest_reg(o_rd),
      .rsp_write_value(o_val), .rsp_halted(o_halt), .rsp_exit_code(o_exit),
      .rsp_access_fault(o_fault)
   );

   assign rsp.payload = {o_pc, o_wr, o_rd, o_val, o_halt, o_exit, o_fault};
endmodule

@@ sv/rv32_ctrl.sv @@
// ----------------------------------------------------------------------------
// rv32_ctrl: sequencing state machine
// Clears memory after reset, then steps each request word through phases.
// ----------------------------------------------------------------------------
module rv32_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rv32_pkg::stat_type  stat,
   output rv32_pkg::ctrl_type  ctrl
);
   rv32_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rv32_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         rv32_pkg::ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_done) state_in = rv32_pkg::ST_IDLE;
         end
         rv32_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == rv32_pkg::CMD_WRITE) begin
                  ctrl.host_write = 1'b1;
                  state_in = rv32_pkg::ST_RESP;
               end else if (stat.halted) begin
                  ctrl.no_op = 1'b1;
                  state_in = rv32_pkg::ST_RESP;
               end else begin
                  ctrl.fetch_start = 1'b1;
                  state_in = rv32_pkg::ST_FETCH;
               end
            end
         end
         rv32_pkg::ST_FETCH: begin
            if (stat.fetch_fault) begin
               state_in = rv32_pkg::ST_RESP;
            end else begin
               ctrl.fetch_step = 1'b1;
               if (stat.fetch_done) state_in = rv32_pkg::ST_DECODE;
            end
         end
         rv32_pkg::ST_DECODE: begin
            ctrl.decode = 1'b1;
            state_in = rv32_pkg::ST_EXEC;
         end
         rv32_pkg::ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in = stat.is_mem ? rv32_pkg::ST_MEM : rv32_pkg::ST_WB;
         end
         rv32_pkg::ST_MEM: begin
            ctrl.mem_step = 1'b1;
            if (stat.mem_done) state_in = rv32_pkg::ST_WB;
         end
         rv32_pkg::ST_WB: begin
            ctrl.wb = 1'b1;
            state_in = rv32_pkg::ST_RESP;
         end
         rv32_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = rv32_pkg::ST_IDLE;
            end
         end
         default: state_in = rv32_pkg::ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == rv32_pkg::ST_IDLE) else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> (!rsp_valid_ff || rsp_ready)) else $error("rsp overwrite");
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.fetch_step, ctrl.mem_step, ctrl.clear_step, ctrl.host_write}))
      else $error("memory port conflict");
endmodule

@@ sv/rv32_datapath.sv @@
// ----------------------------------------------------------------------------
// rv32_datapath: register file, byte memory, ALU and result register
// One byte memory access per cycle, driven by controller commands.
// ----------------------------------------------------------------------------
module rv32_datapath #(
   parameter int MEM_ADDR_BITS = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  rv32_pkg::ctrl_type ctrl,
   output rv32_pkg::stat_type stat,
   input  logic [18:0]        req_address,
   input  logic [7:0]         req_data_byte,
   output logic [31:0]        rsp_next_pc,
   output logic               rsp_reg_written,
   output logic [4:0]         rsp_dest_reg,
   output logic [31:0]        rsp_write_value,
   output logic               rsp_halted,
   output logic [7:0]         rsp_exit_code,
   output logic               rsp_access_fault
);
   localparam int AW = MEM_ADDR_BITS;
   localparam logic [32:0] MEM_SIZE = 33'd1 << AW;

   logic [7:0]  mem [0:(1<<AW)-1];
   logic [31:0] rf [0:31];
   logic [7:0]  rd_byte_ff;

   logic [AW-1:0] clr_ptr_ff;
   logic          clr_done_ff;
   logic [31:0]   pc_ff, pc_in;
   logic          halt_ff;
   logic [31:0]   ins_ff;
   logic [2:0]    cnt_ff;
   logic          rd_pend_ff;
   logic [1:0]    rd_idx_ff;
   logic [31:0]   a_ff, b_ff;
   logic [31:0]   ea_ff, val_ff, next_ff;
   logic          wr_ff, fault_ff, mem_ld_ff, mem_st_ff, halt_now_ff;
   logic [2:0]    nbytes_ff;
   logic          host_fault_ff;

   logic [6:0]  op;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic        alt;
   logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
   logic [31:0] ins_word;
   assign op    = ins_ff[6:0];
   assign f3    = ins_ff[14:12];
   assign rd    = ins_ff[11:7];
   assign alt   = ins_ff[30];
   assign imm_i = {{20{ins_ff[31]}}, ins_ff[31:20]};
   assign imm_s = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign imm_b = {{20{ins_ff[31]}}, ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
   assign imm_u = {ins_ff[31:12], 12'd0};
   assign imm_j = {{12{ins_ff[31]}}, ins_ff[19:12], ins_ff[20], ins_ff[30:21], 1'b0};
   // top fetch byte is still in flight during decode
   assign ins_word = rd_pend_ff ? {rd_byte_ff, ins_ff[23:0]} : ins_ff;

   function automatic logic in_mem(input logic [31:0] addr, input logic [2:0] n);
      return ({1'b0, addr} + {30'd0, n}) <= MEM_SIZE;
   endfunction

   // memory port address / write
   logic [AW-1:0] maddr;
   logic          mwe;
   logic [7:0]    mwdata;
   logic [31:0]   byte_addr;
   always_comb begin
      byte_addr = 32'd0;
      mwe       = 1'b0;
      mwdata    = 8'd0;
      priority if (ctrl.clear_step) begin
         byte_addr = {{(32-AW){1'b0}}, clr_ptr_ff};
         mwe       = 1'b1;
      end else if (ctrl.host_write) begin
         byte_addr = {13'd0, req_address};
         mwe       = ({13'd0, req_address} < MEM_SIZE[31:0]) || (AW >= 19);
         mwdata    = req_data_byte;
      end else if (ctrl.fetch_step) begin
         byte_addr = pc_ff + {29'd0, cnt_ff};
      end else if (ctrl.mem_step) begin
         byte_addr = ea_ff + {29'd0, cnt_ff};
         mwe       = mem_st_ff && (cnt_ff < nbytes_ff);
         mwdata    = b_ff[8*cnt_ff[1:0] +: 8];
      end
   end
   assign maddr = byte_addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwdata;
      rd_byte_ff <= mem[maddr];
   end

   // alu
   logic [31:0] alu_b, alu_out;
   logic        alu_alt;
   logic        take;
   always_comb begin
      alu_b   = (op == rv32_pkg::OP_REG) ? b_ff : imm_i;
      alu_alt = (op == rv32_pkg::OP_REG) ? ((f3 == 3'd0 || f3 == 3'd5) && alt)
                                         : (f3 == 3'd5 && alt);
      unique case (f3)
         3'd0: alu_out = alu_alt ? a_ff - alu_b : a_ff + alu_b;
         3'd1: alu_out = a_ff << alu_b[4:0];
         3'd2: alu_out = {31'd0, $signed(a_ff) < $signed(alu_b)};
         3'd3: alu_out = {31'd0, a_ff < alu_b};
         3'd4: alu_out = a_ff ^ alu_b;
         3'd5: alu_out = alu_alt ? 32'($signed(a_ff) >>> alu_b[4:0]) : a_ff >> alu_b[4:0];
         3'd6: alu_out = a_ff | alu_b;
         default: alu_out = a_ff & alu_b;
      endcase
      unique case (f3)
         3'd0: take = a_ff == b_ff;
         3'd1: take = a_ff != b_ff;
         3'd4: take = $signed(a_ff) < $signed(b_ff);
         3'd5: take = !($signed(a_ff) < $signed(b_ff));
         3'd6: take = a_ff < b_ff;
         3'd7: take = a_ff >= b_ff;
         default: take = 1'b0;
      endcase
   end

   logic [31:0] ld_ext;
   always_comb begin
      unique case (f3)
         3'd0: ld_ext = {{24{val_ff[7]}}, val_ff[7:0]};
         3'd1: ld_ext = {{16{val_ff[15]}}, val_ff[15:0]};
         3'd4: ld_ext = {24'd0, val_ff[7:0]};
         3'd5: ld_ext = {16'd0, val_ff[15:0]};
         default: ld_ext = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clr_done_ff <= 1'b0;
         pc_ff       <= 32'd0;
         halt_ff     <= 1'b0;
         rd_pend_ff  <= 1'b0;
         for (int i = 0; i < 32; i++) rf[i] <= 32'd0;
      end else begin
         rd_pend_ff <= 1'b0;
         if (ctrl.clear_step) begin
            clr_ptr_ff  <= clr_ptr_ff + 1'b1;
            clr_done_ff <= &clr_ptr_ff;
         end
         if (ctrl.fetch_start) begin
            cnt_ff      <= 3'd0;
            fault_ff    <= !in_mem(pc_ff, 3'd4);
            wr_ff       <= 1'b0;
            halt_now_ff <= 1'b0;
            mem_ld_ff   <= 1'b0;
            mem_st_ff   <= 1'b0;
         end
         if (ctrl.host_write) begin
            host_fault_ff <= ({13'd0, req_address} >= MEM_SIZE[31:0]) && (AW < 19);
         end
         if (ctrl.fetch_step || ctrl.mem_step) begin
            cnt_ff     <= cnt_ff + 3'd1;
            rd_pend_ff <= !cnt_ff[2] && (ctrl.fetch_step || mem_ld_ff);
            rd_idx_ff  <= cnt_ff[1:0];
         end
         if (rd_pend_ff) begin
            if (mem_ld_ff) val_ff[8*rd_idx_ff +: 8] <= rd_byte_ff;
            else           ins_ff[8*rd_idx_ff +: 8] <= rd_byte_ff;
         end
         if (ctrl.decode) begin
            a_ff <= rf[ins_word[19:15]];
            b_ff <= rf[ins_word[24:20]];
         end
         if (ctrl.exec) begin
            cnt_ff  <= 3'd0;
            next_ff <= pc_ff + 32'd4;
            wr_ff   <= 1'b0;
            val_ff  <= 32'd0;
            if (ins_ff == rv32_pkg::HALT_WORD) begin
               halt_now_ff <= 1'b1;
            end else begin
               unique case (op)
                  rv32_pkg::OP_LUI: begin wr_ff <= 1'b1; val_ff <= imm_u; end
                  rv32_pkg::OP_AUIPC: begin wr_ff <= 1'b1; val_ff <= pc_ff + imm_u; end
                  rv32_pkg::OP_JAL: begin
                     wr_ff <= 1'b1; val_ff <= pc_ff + 32'd4; next_ff <= pc_ff + imm_j;
                  end
                  rv32_pkg::OP_JALR: begin
                     wr_ff <= 1'b1; val_ff <= pc_ff + 32'd4;
                     next_ff <= (a_ff + imm_i) & ~32'd1;
                  end
                  rv32_pkg::OP_BRANCH: if (take) next_ff <= pc_ff + imm_b;
                  rv32_pkg::OP_LOAD: begin
                     ea_ff <= a_ff + imm_i;
                     nbytes_ff <= (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
                     if (!(f3 == 3'd3 || f3 > 3'd5)) begin
                        if (!in_mem(a_ff + imm_i,
                              (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4))
                           fault_ff <= 1'b1;
                        else begin
                           mem_ld_ff <= 1'b1; wr_ff <= 1'b1;
                        end
                     end
                  end
                  rv32_pkg::OP_STORE: begin
                     ea_ff <= a_ff + imm_s;
                     nbytes_ff <= 3'd1 << f3[1:0];
                     if (f3 <= 3'd2) begin
                        if (!in_mem(a_ff + imm_s, 3'd1 << f3[1:0])) fault_ff <= 1'b1;
                        else mem_st_ff <= 1'b1;
                     end
                  end
                  rv32_pkg::OP_IMM, rv32_pkg::OP_REG: begin
                     wr_ff <= 1'b1; val_ff <= alu_out;
                  end
                  default: ;
               endcase
            end
         end
         if (ctrl.wb) begin
            pc_ff <= next_ff;
            if (halt_now_ff) halt_ff <= 1'b1;
            if (mem_ld_ff) val_ff <= ld_ext;
            if (wr_ff && rd != 5'd0) rf[rd] <= mem_ld_ff ? ld_ext : val_ff;
            else wr_ff <= 1'b0;
         end
      end
   end

   assign stat.clear_done  = clr_done_ff;
   assign stat.fetch_done  = cnt_ff == 3'd3;
   assign stat.fetch_fault = fault_ff && cnt_ff == 3'd0 && !rd_pend_ff;
   assign stat.is_mem      = mem_ld_ff || mem_st_ff
                             || (op == rv32_pkg::OP_LOAD && !(f3 == 3'd3 || f3 > 3'd5)
                                 && in_mem(a_ff + imm_i,
                                    (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4)
                                 && ins_ff != rv32_pkg::HALT_WORD)
                             || (op == rv32_pkg::OP_STORE && f3 <= 3'd2
                                 && in_mem(a_ff + imm_s, 3'd1 << f3[1:0])
                                 && ins_ff != rv32_pkg::HALT_WORD);
   assign stat.mem_done    = cnt_ff == 3'd4;
   assign stat.halted      = halt_ff;

   // result register
   logic kind_ff;
   logic noop_ff;
   always_ff @(posedge clock) begin
      if (ctrl.host_write) kind_ff <= 1'b0;
      if (ctrl.fetch_start || ctrl.no_op) kind_ff <= 1'b1;
      if (ctrl.no_op) noop_ff <= 1'b1;
      if (ctrl.fetch_start || ctrl.host_write) noop_ff <= 1'b0;
      if (ctrl.load_rsp) begin
         rsp_next_pc      <= pc_ff;
         rsp_halted       <= halt_ff;
         rsp_exit_code    <= halt_ff ? rf[10][7:0] : 8'd0;
         if (kind_ff && !noop_ff) begin
            rsp_reg_written  <= wr_ff && rd != 5'd0 && !fault_ff;
            rsp_dest_reg     <= (wr_ff && rd != 5'd0 && !fault_ff) ? rd : 5'd0;
            rsp_write_value  <= (wr_ff && rd != 5'd0 && !fault_ff) ? val_ff : 32'd0;
            rsp_access_fault <= fault_ff;
         end else begin
            rsp_reg_written  <= 1'b0;
            rsp_dest_reg     <= 5'd0;
            rsp_write_value  <= 32'd0;
            rsp_access_fault <= kind_ff ? 1'b0 : host_fault_ff;
         end
      end
   end

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      (ctrl.no_op || ctrl.host_write) |=> $stable(pc_ff)) else $error("pc moved");
   a_x0: assert property (@(posedge clock) disable iff (reset)
      rf[0] == 32'd0) else $error("x0 written");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) |-> halt_ff) else $error("halt cleared");
endmodule
